@@ rtl/sht_pkg.sv @@
package sht_pkg;

  // Table geometry.
  localparam int CAPACITY = 64;
  localparam int KEY_W    = 31;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // Operation codes.
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // Input beat.
  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] scl_x;
    logic [WORD_W-1:0] scl_y;
    logic [WORD_W-1:0] scl_z;
    logic [WORD_W-1:0] rot_word;
  } sht_in_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]        status;
    logic [KEY_W-1:0]  out_key;
    logic [WORD_W-1:0] out_pos_x;
    logic [WORD_W-1:0] out_pos_y;
    logic [WORD_W-1:0] out_pos_z;
    logic [WORD_W-1:0] out_scl_x;
    logic [WORD_W-1:0] out_scl_y;
    logic [WORD_W-1:0] out_scl_z;
    logic [WORD_W-1:0] out_rot;
  } sht_out_t;

  // Seven-word payload held by each cell.
  typedef struct packed {
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] scl_x;
    logic [WORD_W-1:0] scl_y;
    logic [WORD_W-1:0] scl_z;
    logic [WORD_W-1:0] rot;
  } sht_pay_t;

  // One stored entry.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    sht_pay_t         pay;
  } sht_entry_t;

  // Readout word that travels down the chain towards cell zero.
  typedef struct packed {
    logic     hit;
    sht_pay_t pay;
  } sht_rd_t;

  // Command broadcast to every cell.
  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_MATCH,
    CMD_SHIFT,
    CMD_REMOVE,
    CMD_WRITE
  } sht_cmd_e;

  typedef struct packed {
    sht_cmd_e         cmd;
    logic [KEY_W-1:0] key;
    sht_entry_t       wr_entry;
  } sht_cell_ctrl_t;

endpackage

@@ rtl/sht_cell.sv @@
module sht_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sht_pkg::sht_cell_ctrl_t ctrl_i,
  input  logic                    valid_i,
  input  logic                    wr_sel_i,
  input  sht_pkg::sht_entry_t     nbr_entry_i,
  input  sht_pkg::sht_rd_t        nbr_rd_i,
  output sht_pkg::sht_entry_t     entry_o,
  output sht_pkg::sht_rd_t        rd_o
);
  import sht_pkg::*;

  sht_entry_t entry_q;
  sht_rd_t    rd_q;
  logic       ge_q;
  logic       hit;
  logic       ge;

  // Local compare against the broadcast key; invalid cells never match.
  assign hit = valid_i && (entry_q.key == ctrl_i.key);
  assign ge  = valid_i && (entry_q.key >= ctrl_i.key);

  // Stored entry: written on create, taken from the upper neighbour on removal.
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      CMD_WRITE: begin
        if (wr_sel_i) begin
          entry_q <= ctrl_i.wr_entry;
        end
      end
      CMD_REMOVE: begin
        if (ge_q) begin
          entry_q <= nbr_entry_i;
        end
      end
      default: begin
      end
    endcase
  end

  // Readout chain: a hit is loaded locally, then ORed down towards cell zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      ge_q <= 1'b0;
    end else begin
      unique case (ctrl_i.cmd)
        CMD_MATCH: begin
          rd_q.hit <= hit;
          rd_q.pay <= hit ? entry_q.pay : '0;
          ge_q     <= ge;
        end
        CMD_SHIFT: begin
          rd_q <= rd_q | nbr_rd_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;

endmodule

@@ rtl/sht_ctrl.sv @@
module sht_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sht_pkg::sht_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sht_pkg::sht_out_t             out_data_o,
  input  sht_pkg::sht_rd_t              head_rd_i,
  output sht_pkg::sht_cell_ctrl_t       cell_ctrl_o,
  output logic [sht_pkg::CNT_W-1:0]     count_o
);
  import sht_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [1:0]       op_q;
  logic [KEY_W-1:0] key_q;
  sht_pay_t         pay_q;
  logic [CNT_W-1:0] cnt_q;
  logic [KEY_W-1:0] next_key_q;
  logic             exh_q;
  logic [IDX_W-1:0] scan_q;
  logic             out_valid_q;
  sht_out_t         out_q;

  logic     out_free;
  logic     full;
  sht_out_t resp;

  assign out_free   = !out_valid_q || out_ready_i;
  assign full       = exh_q || (cnt_q == CNT_W'(CAPACITY));
  assign in_ready_o = (state_q == ST_IDLE);

  // Command of the beat being served, captured at acceptance.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q        <= in_data_i.op;
      key_q       <= in_data_i.key;
      pay_q.pos_x <= in_data_i.pos_x;
      pay_q.pos_y <= in_data_i.pos_y;
      pay_q.pos_z <= in_data_i.pos_z;
      pay_q.scl_x <= in_data_i.scl_x;
      pay_q.scl_y <= in_data_i.scl_y;
      pay_q.scl_z <= in_data_i.scl_z;
      pay_q.rot   <= in_data_i.rot_word;
    end
  end

  // Result of the current operation, formed once the chain has settled.
  always_comb begin
    resp         = '0;
    resp.out_key = key_q;
    resp.status  = STAT_NOT_FOUND;
    unique case (op_q)
      OP_CREATE: begin
        if (full) begin
          resp.status  = STAT_FULL;
          resp.out_key = '0;
        end else begin
          resp.status  = STAT_OK;
          resp.out_key = next_key_q;
        end
      end
      OP_LOOKUP: begin
        if (head_rd_i.hit) begin
          resp.status    = STAT_OK;
          resp.out_pos_x = head_rd_i.pay.pos_x;
          resp.out_pos_y = head_rd_i.pay.pos_y;
          resp.out_pos_z = head_rd_i.pay.pos_z;
          resp.out_scl_x = head_rd_i.pay.scl_x;
          resp.out_scl_y = head_rd_i.pay.scl_y;
          resp.out_scl_z = head_rd_i.pay.scl_z;
          resp.out_rot   = head_rd_i.pay.rot;
        end
      end
      OP_REMOVE: begin
        if (head_rd_i.hit) begin
          resp.status = STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Commands to the cells, decoded from the current state.
  always_comb begin
    cell_ctrl_o              = '0;
    cell_ctrl_o.cmd          = CMD_IDLE;
    cell_ctrl_o.key          = key_q;
    cell_ctrl_o.wr_entry.key = next_key_q;
    cell_ctrl_o.wr_entry.pay = pay_q;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_MATCH: begin
        cell_ctrl_o.cmd = CMD_MATCH;
      end
      ST_SCAN: begin
        if (scan_q != '0) begin
          cell_ctrl_o.cmd = CMD_SHIFT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (op_q == OP_CREATE && !full) begin
            cell_ctrl_o.cmd = CMD_WRITE;
          end else if (op_q == OP_REMOVE && head_rd_i.hit) begin
            cell_ctrl_o.cmd = CMD_REMOVE;
          end
        end
      end
    endcase
  end

  // Sequencer, table bookkeeping and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      next_key_q  <= '0;
      exh_q       <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.op == OP_LOOKUP || in_data_i.op == OP_REMOVE) begin
              state_q <= ST_MATCH;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_MATCH: begin
          scan_q  <= (cnt_q == '0) ? '0 : IDX_W'(cnt_q - 1'b1);
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            scan_q <= scan_q - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= resp;
            state_q     <= ST_IDLE;
            if (op_q == OP_CREATE && !full) begin
              cnt_q <= cnt_q + 1'b1;
              if (next_key_q == KEY_MAX) begin
                exh_q <= 1'b1;
              end else begin
                next_key_q <= next_key_q + 1'b1;
              end
            end else if (op_q == OP_REMOVE && head_rd_i.hit) begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign count_o     = cnt_q;

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The chain is only scanned for lookups and removals.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (op_q == OP_LOOKUP || op_q == OP_REMOVE))
    else $error("scan for an operation that needs none");

  // The fill count only moves when a result is issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == ST_DONE && out_valid_q))
    else $error("entry count changed outside result issue");

  // An exhausted key space leaves the counter at the last key.
  assert property (@(posedge clk_i) disable iff (!rst_ni) exh_q |-> (next_key_q == KEY_MAX))
    else $error("key counter moved after exhaustion");

  // A removal that shifts the chain reports success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_ctrl_o.cmd == CMD_REMOVE) |=> (out_valid_q && out_q.status == STAT_OK))
    else $error("removal without a successful result");

endmodule

@@ rtl/sorted_handle_table.sv @@
// Create: an accepted beat moves the sequencer to its done state, and from there the
// result is registered into the output register once that register is free. Lookup and
// remove pass through the match and scan states first, and the scan covers only the
// stored entries; the readout walks the chain one cell a cycle. One beat at a time; ready
// returns with the result, so output stalls also hold the table busy. Reset clears the fill
// count, key counter and exhausted flag; cell contents stay undefined, masked by the fill count.
module sorted_handle_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sht_pkg::sht_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sht_pkg::sht_out_t out_data_o
);
  import sht_pkg::*;

  sht_cell_ctrl_t   cell_ctrl;
  logic [CNT_W-1:0] count;
  sht_entry_t       entry [CAPACITY];
  sht_rd_t          rd    [CAPACITY];
  logic             valid [CAPACITY];
  logic             wr_sel[CAPACITY];

  // Sequencer and bookkeeping.
  sht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .head_rd_i   (rd[0]),
    .cell_ctrl_o (cell_ctrl),
    .count_o     (count)
  );

  // Row of cells; each takes entry and readout data from its upper neighbour.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sht_entry_t nbr_entry;
    sht_rd_t    nbr_rd;

    assign valid[g]  = (CNT_W'(g) < count);
    assign wr_sel[g] = (CNT_W'(g) == count);

    if (g == CAPACITY - 1) begin : g_tail
      assign nbr_entry = '0;
      assign nbr_rd    = '0;
    end else begin : g_body
      assign nbr_entry = entry[g+1];
      assign nbr_rd    = rd[g+1];
    end

    sht_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .valid_i     (valid[g]),
      .wr_sel_i    (wr_sel[g]),
      .nbr_entry_i (nbr_entry),
      .nbr_rd_i    (nbr_rd),
      .entry_o     (entry[g]),
      .rd_o        (rd[g])
    );
  end

endmodule
